// File: rtl/swpa_pkg.sv
package swpa_pkg;

   // Beat layout and field widths
   localparam int COORD_W    = 10;
   localparam int POS_W      = 19;
   localparam int VALUE_W    = 17;
   localparam int THICK_W    = 16;
   localparam int TOL_W      = 16;
   localparam int GRID_W     = 11;
   localparam int AREA_W     = 2 * GRID_W;
   localparam int ID_W       = 30;
   localparam int WEIGHT_W   = 10;
   localparam int EDGE_W     = 22;
   localparam int YCOL_W     = COORD_W + GRID_W;
   localparam int ZPROD_W    = COORD_W + AREA_W;
   localparam int PROD_W     = VALUE_W + WEIGHT_W;
   localparam int WFRAC_W    = 9;
   localparam int ADD_W      = PROD_W - WFRAC_W;
   localparam int SUM_W      = 32;
   localparam int LIMIT_W    = 17;

   localparam int X_LSB      = 0;
   localparam int Y_LSB      = X_LSB + COORD_W;
   localparam int Z_LSB      = Y_LSB + COORD_W;
   localparam int POS_LSB    = Z_LSB + COORD_W;
   localparam int VALUE_LSB  = POS_LSB + POS_W;
   localparam int REQ_DATA_W = 72;

   localparam int FRAC_LSB   = ID_W;
   localparam int RSP_USED_W = ID_W + VALUE_W;
   localparam int RSP_DATA_W = 48;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   localparam int COORD_BITS_DEFAULT = 10;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // One slice in Q.9, half a slice in Q.9, one in Q.16
   localparam logic [WEIGHT_W-1:0]      WEIGHT_ONE = WEIGHT_W'(512);
   localparam logic signed [EDGE_W-1:0] HALF_SLICE = EDGE_W'(256);
   localparam logic [SUM_W-1:0]         ONE_Q16    = SUM_W'(65536);
   localparam logic [SUM_W-1:0]         SUM_MAX    = {SUM_W{1'b1}};

   // Register map (word index)
   localparam logic [REG_IDX_W-1:0] REG_PLANE_THICKNESS = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_TOLERANCE       = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_STRICT_MODE     = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] REG_GRID_COLUMNS    = REG_IDX_W'(3);
   localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS       = REG_IDX_W'(4);

   localparam logic [THICK_W-1:0] THICK_RESET  = THICK_W'(256);
   localparam logic [TOL_W-1:0]   TOL_RESET    = TOL_W'(1);
   localparam logic [GRID_W-1:0]  GRID_RESET   = GRID_W'(512);
   localparam logic [AREA_W-1:0]  AREA_RESET   = AREA_W'(262144);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(65537);

   typedef struct packed {
      logic [THICK_W-1:0] thick;
      logic [TOL_W-1:0]   tol;
      logic               strict_en;
      logic [GRID_W-1:0]  cols;
      logic [GRID_W-1:0]  rows;
      logic [AREA_W-1:0]  area;
      logic [LIMIT_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0]  x;
      logic [YCOL_W-1:0]   ycol;
      logic [ID_W-1:0]     zarea;
      logic [VALUE_W-1:0]  value;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } q_entry_type;

endpackage

// File: rtl/swpa_csr.sv
module swpa_csr import swpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [THICK_W-1:0]   thick_ff;
   logic [TOL_W-1:0]     tol_ff;
   logic                 strict_ff;
   logic [GRID_W-1:0]    cols_ff;
   logic [GRID_W-1:0]    rows_ff;
   logic [AREA_W-1:0]    area_ff;
   logic [AREA_W-1:0]    area_in;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [LIMIT_W-1:0]   limit_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Derived values are registered and follow the registers in the next cycle
   assign area_in  = AREA_W'(cols_ff) * AREA_W'(rows_ff);
   assign limit_in = LIMIT_W'(ONE_Q16) + LIMIT_W'(tol_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff  <= THICK_RESET;
         tol_ff    <= TOL_RESET;
         strict_ff <= 1'b1;
         cols_ff   <= GRID_RESET;
         rows_ff   <= GRID_RESET;
         area_ff   <= AREA_RESET;
         limit_ff  <= LIMIT_RESET;
      end else begin
         area_ff  <= area_in;
         limit_ff <= limit_in;
         if (wr_en) begin
            case (reg_idx)
               REG_PLANE_THICKNESS: thick_ff  <= csr_pwdata[THICK_W-1:0];
               REG_TOLERANCE:       tol_ff    <= csr_pwdata[TOL_W-1:0];
               REG_STRICT_MODE:     strict_ff <= csr_pwdata[0];
               REG_GRID_COLUMNS:    cols_ff   <= csr_pwdata[GRID_W-1:0];
               REG_GRID_ROWS:       rows_ff   <= csr_pwdata[GRID_W-1:0];
               default:             ;
            endcase
         end
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PLANE_THICKNESS: csr_prdata = CSR_DATA_W'(thick_ff);
         REG_TOLERANCE:       csr_prdata = CSR_DATA_W'(tol_ff);
         REG_STRICT_MODE:     csr_prdata = CSR_DATA_W'(strict_ff);
         REG_GRID_COLUMNS:    csr_prdata = CSR_DATA_W'(cols_ff);
         REG_GRID_ROWS:       csr_prdata = CSR_DATA_W'(rows_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.thick     = thick_ff;
      cfg.tol       = tol_ff;
      cfg.strict_en = strict_ff;
      cfg.cols      = cols_ff;
      cfg.rows      = rows_ff;
      cfg.area      = area_ff;
      cfg.limit     = limit_ff;
   end

endmodule

// File: rtl/swpa_front.sv
module swpa_front import swpa_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [REQ_DATA_W-1:0] in_data,
   input  logic                  in_last,
   input  cfg_type               cfg,
   output logic                  push_valid,
   output q_entry_type           push_data,
   input  logic                  push_full
);

   localparam logic [COORD_W-1:0] CoordMask = (COORD_BITS >= COORD_W) ?
      {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

   // Stage 1: slab and voxel edges in Q.9
   logic                       s1_valid_ff;
   logic [COORD_W-1:0]         s1_x_ff, s1_y_ff, s1_z_ff;
   logic [VALUE_W-1:0]         s1_value_ff;
   logic                       s1_last_ff;
   logic signed [EDGE_W-1:0]   s1_pmin_ff, s1_pmax_ff, s1_zlo_ff, s1_zhi_ff;
   logic signed [EDGE_W-1:0]   pmin_in, pmax_in, zlo_in, zhi_in;
   logic signed [EDGE_W-1:0]   pos2, thick_x, zc;
   logic [POS_W-1:0]           pos_raw;
   logic [COORD_W-1:0]         x_in, y_in, z_in;

   // Stage 2: weight and partial grid products
   logic                       s2_valid_ff;
   q_entry_type                s2_entry_ff;
   q_entry_type                s2_entry_in;
   logic [WEIGHT_W-1:0]        weight_in;
   logic signed [EDGE_W-1:0]   d_max_zlo, d_max_min, d_zhi_min;
   logic [ZPROD_W-1:0]         zarea_full;

   logic advance;
   logic s1_load;

   assign advance  = !s2_valid_ff || !push_full;
   assign s1_load  = !s1_valid_ff || advance;
   assign in_ready = s1_load;

   assign x_in    = in_data[X_LSB +: COORD_W] & CoordMask;
   assign y_in    = in_data[Y_LSB +: COORD_W] & CoordMask;
   assign z_in    = in_data[Z_LSB +: COORD_W] & CoordMask;
   assign pos_raw = in_data[POS_LSB +: POS_W];

   assign pos2    = {{(EDGE_W - POS_W - 1){pos_raw[POS_W-1]}}, pos_raw, 1'b0};
   assign thick_x = {{(EDGE_W - THICK_W){1'b0}}, cfg.thick};
   assign zc      = {{(EDGE_W - COORD_W - WFRAC_W){1'b0}}, z_in, {WFRAC_W{1'b0}}};
   assign pmin_in = pos2 - thick_x;
   assign pmax_in = pos2 + thick_x;
   assign zlo_in  = zc - HALF_SLICE;
   assign zhi_in  = zc + HALF_SLICE;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_x_ff     <= x_in;
         s1_y_ff     <= y_in;
         s1_z_ff     <= z_in;
         s1_value_ff <= in_data[VALUE_LSB +: VALUE_W];
         s1_last_ff  <= in_last;
         s1_pmin_ff  <= pmin_in;
         s1_pmax_ff  <= pmax_in;
         s1_zlo_ff   <= zlo_in;
         s1_zhi_ff   <= zhi_in;
      end
   end

   assign d_max_zlo = s1_pmax_ff - s1_zlo_ff;
   assign d_max_min = s1_pmax_ff - s1_pmin_ff;
   assign d_zhi_min = s1_zhi_ff - s1_pmin_ff;

   // Overlap of the slab with the voxel slab, capped at one slice
   always_comb begin
      if (s1_pmin_ff < s1_zlo_ff && s1_pmax_ff > s1_zlo_ff) begin
         weight_in = (s1_pmax_ff < s1_zhi_ff) ? d_max_zlo[WEIGHT_W-1:0] : WEIGHT_ONE;
      end else if (s1_pmin_ff >= s1_zlo_ff && s1_pmin_ff < s1_zhi_ff) begin
         weight_in = (s1_pmax_ff < s1_zhi_ff) ? d_max_min[WEIGHT_W-1:0]
                                              : d_zhi_min[WEIGHT_W-1:0];
      end else begin
         weight_in = '0;
      end
   end

   assign zarea_full = ZPROD_W'(s1_z_ff) * ZPROD_W'(cfg.area);

   always_comb begin
      s2_entry_in.x      = s1_x_ff;
      s2_entry_in.ycol   = YCOL_W'(s1_y_ff) * YCOL_W'(cfg.cols);
      s2_entry_in.zarea  = zarea_full[ID_W-1:0];
      s2_entry_in.value  = s1_value_ff;
      s2_entry_in.weight = weight_in;
      s2_entry_in.last   = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_entry_ff <= s2_entry_in;
      end
   end

   assign push_valid = s2_valid_ff && !push_full;
   assign push_data  = s2_entry_ff;

endmodule

// File: rtl/swpa_queue.sv
module swpa_queue import swpa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_data,
   output logic        full,
   input  logic        pop,
   output q_entry_type pop_data,
   output logic        empty
);

   q_entry_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_in, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/swpa_back.sv
module swpa_back import swpa_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   output logic                  pop,
   input  logic                  pop_empty,
   input  q_entry_type           pop_data,
   input  cfg_type               cfg,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [RSP_DATA_W-1:0] out_data,
   output logic                  out_error
);

   // Stage A: contribution product and linear id
   logic                a_valid_ff;
   logic [PROD_W-1:0]   a_prod_ff, a_prod_in;
   logic [ID_W-1:0]     a_id_ff, a_id_in;
   logic                a_last_ff;
   logic                a_load;

   // Stage B: accumulator and result register
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    total;
   logic                b_take;
   logic                out_valid_ff, out_valid_in;
   logic [ID_W-1:0]     out_id_ff;
   logic [VALUE_W-1:0]  out_frac_ff, frac_in;
   logic                out_err_ff, err_in;
   logic                emit;

   assign b_take = a_valid_ff && (!a_last_ff || !out_valid_ff || out_ready);
   assign a_load = !a_valid_ff || b_take;
   assign pop    = a_load && !pop_empty;

   assign a_prod_in = PROD_W'(pop_data.value) * PROD_W'(pop_data.weight);
   assign a_id_in   = ID_W'(pop_data.x) + ID_W'(pop_data.ycol) + pop_data.zarea;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= !pop_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_prod_ff <= a_prod_in;
         a_id_ff   <= a_id_in;
         a_last_ff <= pop_data.last;
      end
   end

   // Saturating accumulate, then clamp or flag the run total
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(a_prod_ff[PROD_W-1:WFRAC_W]);
   assign total    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   always_comb begin
      frac_in = total[VALUE_W-1:0];
      err_in  = 1'b0;
      if (total > ONE_Q16) begin
         if (total <= SUM_W'(cfg.limit) || !cfg.strict_en) begin
            frac_in = ONE_Q16[VALUE_W-1:0];
         end else begin
            frac_in = '0;
            err_in  = 1'b1;
         end
      end
   end

   assign emit = (frac_in != '0) || err_in;

   always_comb begin
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (b_take) begin
         sum_in = a_last_ff ? '0 : total;
         if (a_last_ff && emit) begin
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_take && a_last_ff && emit) begin
         out_id_ff   <= a_id_ff;
         out_frac_ff <= frac_in;
         out_err_ff  <= err_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = RSP_DATA_W'({out_frac_ff, out_id_ff});
   assign out_error = out_err_ff;

endmodule

// File: rtl/slab_weighted_plane_accumulator_unit.sv
// Channel  Direction  Beat contents
// req      in         tdata: voxel_x, voxel_y, slice_z, plane_position, plane_value;
//                     tlast: last_plane
// rsp      out        tdata: grid_id, fraction; tuser: overflow_error
// csr      in/out     APB-style register access, pready tied high
//
// Throughput: one req beat per cycle while rsp keeps up; the per-voxel
// accumulator add is the only value carried from one beat to the next.
// Path: a last_plane beat reaches rsp through two front stages, one queue
// slot and the product stage, which lead into the result register.
// Reset: synchronous; registers return to their documented defaults, the
// accumulator clears, and no memory sweep is needed.
// Stalls: rsp_tready low holds only the back end once a second result is due;
// the four-entry queue and the two front stages then take six more beats
// before req_tready drops.
module slab_weighted_plane_accumulator_unit import swpa_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [9:0] voxel_x, [19:10] voxel_y, [29:20] slice_z, [48:30] plane_position,
   // [65:49] plane_value, [71:66] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [29:0] grid_id, [46:30] fraction, [47] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] overflow_error
   output logic                  rsp_tuser,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type     cfg;
   logic        push_valid;
   q_entry_type push_data;
   logic        q_full;
   logic        q_pop;
   q_entry_type q_head;
   logic        q_empty;

   // Register file; also holds cols*rows and the one-plus-tolerance limit
   swpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Front end: mask coordinates, derive slab overlap weight and id partials
   swpa_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .in_last    (req_tlast),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_full  (q_full)
   );

   // Decoupling queue between classification and accumulation
   swpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   // Back end: weight the value, accumulate, close the run on last_plane
   swpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (q_pop),
      .pop_empty (q_empty),
      .pop_data  (q_head),
      .cfg       (cfg),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_error (rsp_tuser)
   );

endmodule

// File: rtl/swpa_checker.sv
module swpa_checker import swpa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic [VALUE_W-1:0] frac;

   assign frac = rsp_tdata[FRAC_LSB +: VALUE_W];

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // Fraction never exceeds one and padding stays zero
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> frac <= ONE_Q16[VALUE_W-1:0] && rsp_tdata[RSP_DATA_W-1:RSP_USED_W] == '0)
      else $error("fraction above one or nonzero padding");

   // An overflow result carries a zero fraction
   a_err_frac: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> frac == '0)
      else $error("overflow result with nonzero fraction");

   // A normal result is never empty
   a_no_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> frac != '0)
      else $error("empty result emitted");

   // Nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind slab_weighted_plane_accumulator_unit swpa_checker u_checker (.*);

// File: dv/slab_weighted_plane_accumulator_unit_tb.sv
module slab_weighted_plane_accumulator_unit_tb;
   import swpa_pkg::*;

   localparam int      CYCLE_LIMIT = 1000000;
   localparam longint  SLICE_Q9    = 512;
   // Word index past the register map; a write there must change nothing.
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_IDX_W'(5);

   // One plane contribution as it travels on req.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] value;
      logic               is_last;
   } plane_beat_type;

   // One voxel fraction as it travels on rsp.
   typedef struct packed {
      logic [ID_W-1:0]    grid_id;
      logic [VALUE_W-1:0] fraction;
      logic               overflow;
   } voxel_fraction_type;

   // Keeps its own copy of the registers and the per-voxel sum, works out the
   // fraction each closing plane should produce and matches it against rsp.
   class fraction_scoreboard_type;
      logic [THICK_W-1:0] thick;
      logic [TOL_W-1:0]   tol;
      logic               strict_en;
      logic [GRID_W-1:0]  cols;
      logic [GRID_W-1:0]  rows;
      logic [SUM_W-1:0]   fraction_sum;
      voxel_fraction_type expected_fractions[$];
      int                 errors;

      function new();
         thick        = THICK_RESET;
         tol          = TOL_RESET;
         strict_en    = 1'b1;
         cols         = GRID_RESET;
         rows         = GRID_RESET;
         fraction_sum = '0;
         errors       = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_PLANE_THICKNESS: thick = value[THICK_W-1:0];
            REG_TOLERANCE:       tol = value[TOL_W-1:0];
            REG_STRICT_MODE:     strict_en = value[0];
            REG_GRID_COLUMNS:    cols = value[GRID_W-1:0];
            REG_GRID_ROWS:       rows = value[GRID_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_plane(plane_beat_type p);
         longint             centre, t, z_l, pmin, pmax, zmin, zmax, w;
         longint unsigned    val_u, w_u, add, total, x_u, y_u, zu, cols_u, rows_u, id_full;
         logic [SUM_W-1:0]   sum;
         logic [SUM_W-1:0]   frac;
         logic               err;
         voxel_fraction_type r;
         // Edges in Q.9 slices: the slab spans 2*centre -/+ thickness.
         centre = {{(64 - POS_W){p.pos[POS_W-1]}}, p.pos};
         t      = thick;
         z_l    = p.z;
         pmin   = 2 * centre - t;
         pmax   = 2 * centre + t;
         zmin   = (2 * z_l - 1) * 256;
         zmax   = (2 * z_l + 1) * 256;
         if (pmin < zmin && pmax > zmin)
            w = (pmax < zmax) ? (pmax - zmin) : SLICE_Q9;
         else if (pmin >= zmin && pmin < zmax)
            w = (pmax < zmax) ? (2 * t) : (zmax - pmin);
         else
            w = 0;
         if (w > 0) begin
            val_u = p.value;
            w_u   = w;
            add   = (val_u * w_u) >> 9;
            total = fraction_sum + add;
            fraction_sum = (total > 64'hFFFF_FFFF) ? SUM_MAX : total[SUM_W-1:0];
         end
         if (!p.is_last)
            return;
         sum          = fraction_sum;
         fraction_sum = '0;
         frac         = sum;
         err          = 1'b0;
         if (sum > ONE_Q16) begin
            if ((sum - ONE_Q16) <= tol || !strict_en) begin
               frac = ONE_Q16;
            end else begin
               frac = '0;
               err  = 1'b1;
            end
         end
         if (frac == 0 && !err)
            return;
         x_u     = p.x;
         y_u     = p.y;
         zu      = p.z;
         cols_u  = cols;
         rows_u  = rows;
         id_full = x_u + y_u * cols_u + zu * cols_u * rows_u;
         r.grid_id  = id_full[ID_W-1:0];
         r.fraction = frac[VALUE_W-1:0];
         r.overflow = err;
         expected_fractions.insert(expected_fractions.size(), r);
      endfunction

      function void check_fraction(voxel_fraction_type got);
         voxel_fraction_type want;
         if (expected_fractions.size() == 0) begin
            $error("unexpected result: grid_id %0d fraction %0d overflow_error %0d",
                   got.grid_id, got.fraction, got.overflow);
            errors++;
            return;
         end
         want = expected_fractions.pop_front();
         if (got.grid_id !== want.grid_id) begin
            $error("grid_id: expected %0d, got %0d", want.grid_id, got.grid_id);
            errors++;
         end
         if (got.fraction !== want.fraction) begin
            $error("fraction: expected %0d, got %0d", want.fraction, got.fraction);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow_error: expected %0d, got %0d", want.overflow, got.overflow);
            errors++;
         end
      endfunction

      function int waiting();
         return expected_fractions.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fraction_scoreboard_type board;
   int                      items_sent  = 0;
   int                      cycle_count = 0;
   bit                      steady      = 1'b0;

   slab_weighted_plane_accumulator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Bound the run; a hang anywhere ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Favor the grid corners so every index bit sees both values early.
   function automatic logic [COORD_W-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      return COORD_W'($urandom_range(0, 1023));
   endfunction

   // Sample every rsp beat before this edge's updates land.
   always @(posedge clock) begin
      voxel_fraction_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.grid_id  = rsp_tdata[ID_W-1:0];
         got.fraction = rsp_tdata[FRAC_LSB +: VALUE_W];
         got.overflow = rsp_tuser;
         board.check_fraction(got);
      end
   end

   // Receiver: random ready pattern with bursts of steady acceptance. After
   // the 60th and the 200th beat, hold ready low long enough that the queue
   // fills and req backs up while the sender keeps offering.
   initial begin : rsp_side
      int taken, hold_left, holds_done, gap;
      taken      = 0;
      hold_left  = 0;
      holds_done = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            taken++;
         if (hold_left > 0) begin
            hold_left--;
         end else if (holds_done < 2 && taken >= (holds_done == 0 ? 60 : 200)) begin
            holds_done++;
            hold_left = 600;
            rsp_tready <= 1'b0;
         end else if (rsp_tready) begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               hold_left = gap - 1;
            end else begin
               hold_left = $urandom_range(0, 40);
            end
         end else begin
            rsp_tready <= 1'b1;
            hold_left = $urandom_range(0, 40);
         end
      end
   end

   // Offer one plane, wait for the handshake, then log it with the predictor.
   task automatic send_plane(input logic [COORD_W-1:0] x, y, z, input int pos,
                             input int value, input bit is_last);
      plane_beat_type        p;
      logic [REQ_DATA_W-1:0] beat;
      int                    gap;
      p.x       = x;
      p.y       = y;
      p.z       = z;
      p.pos     = pos[POS_W-1:0];
      p.value   = value[VALUE_W-1:0];
      p.is_last = is_last;
      beat = '0;
      beat[X_LSB +: COORD_W]   = p.x;
      beat[Y_LSB +: COORD_W]   = p.y;
      beat[Z_LSB +: COORD_W]   = p.z;
      beat[POS_LSB +: POS_W]   = p.pos;
      beat[VALUE_LSB +: VALUE_W] = p.value;
      req_tdata  <= beat;
      req_tlast  <= is_last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_plane(p);
      items_sent++;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One voxel's run of planes. Mode 0 lands a single centered plane right at
   // the one-slice boundary and the tolerance edge; the rest spread planes
   // around the voxel slab, modes above 3 with values sized so sums hover near one.
   task automatic send_voxel_run();
      int                 mode, len, span, pos, value, i;
      logic [COORD_W-1:0] x, y, z, xi, yi, zi;
      mode = $urandom_range(0, 9);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 4);
      if (mode == 0)
         len = 1;
      x = pick_coord();
      y = pick_coord();
      z = pick_coord();
      span = board.thick / 2 + 300;
      if (span > 4000)
         span = 4000;
      for (i = 0; i < len; i++) begin
         xi = x;
         yi = y;
         zi = z;
         // Stray coordinates mid-run: the sum carries across voxels.
         if ($urandom_range(0, 19) == 0) begin
            xi = pick_coord();
            yi = pick_coord();
            zi = pick_coord();
         end
         if (mode == 0) begin
            pos = int'(zi) * 256;
            if ($urandom_range(0, 1) == 0)
               value = 65536 + $urandom_range(0, 3);
            else
               value = 65535 + board.tol + $urandom_range(0, 2);
         end else begin
            pos = int'(zi) * 256 + $urandom_range(0, 2 * span) - span;
            if ($urandom_range(0, 19) == 0)
               pos = $urandom_range(0, 524287) - 262144;
            if (mode <= 3)
               value = $urandom_range(0, 131071);
            else
               value = $urandom_range(0, 140000 / len);
         end
         if (value > 131071)
            value = 131071;
         send_plane(xi, yi, zi, pos, value, i == len - 1);
      end
   endtask

   // APB write: setup phase, access phase, then idle before the next transfer.
   task automatic write_csr(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.write_reg(idx, value);
      @(posedge clock);
   endtask

   // Drop valid, drain every expected fraction, then let planes that close
   // no result clear the pipe.
   task automatic settle(input int tail);
      req_tvalid <= 1'b0;
      while (board.waiting() > 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   initial begin : stimulus
      int                    k, quota;
      logic [CSR_DATA_W-1:0] thick_v, tol_v, strict_v, cols_v, rows_v;
      board = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < 8; k++) begin
         if (k > 0) begin
            settle(12);
            case (k)
               1: begin thick_v = 1; tol_v = 0; strict_v = 1; cols_v = 1024; rows_v = 1024; end
               2: begin thick_v = 65535; tol_v = 65535; strict_v = 0; cols_v = 2047; rows_v = 2047; end
               // Zero thickness: no plane ever weighs anything.
               3: begin thick_v = 0; tol_v = 0; strict_v = 1; cols_v = 0; rows_v = 0; end
               4: begin thick_v = 384; tol_v = 0; strict_v = 0; cols_v = 0; rows_v = 7; end
               5: begin thick_v = 200; tol_v = 300; strict_v = 1; cols_v = 1; rows_v = 2047; end
               default: begin
                  thick_v  = $urandom_range(1, 1024);
                  tol_v    = $urandom_range(0, 4096);
                  strict_v = $urandom_range(0, 1);
                  cols_v   = $urandom_range(0, 2047);
                  rows_v   = $urandom_range(0, 2047);
               end
            endcase
            write_csr(REG_PLANE_THICKNESS, thick_v);
            write_csr(REG_TOLERANCE, tol_v);
            write_csr(REG_STRICT_MODE, strict_v);
            write_csr(REG_GRID_COLUMNS, cols_v);
            write_csr(REG_GRID_ROWS, rows_v);
            if (k == 3)
               write_csr(REG_UNMAPPED, 32'hFFFF_FFFF);
         end
         steady = (k == 2 || k == 5);

         if (k == 0) begin
            // Reset settings: thickness one slice, tolerance 1, strict.
            send_plane(0, 0, 0, 0, 65536, 1);                         // exactly one
            send_plane(1023, 1023, 1023, 1023 * 256, 65537, 1);       // excess within tolerance
            send_plane(10'h2AA, 10'h155, 3, 3 * 256, 65538, 1);       // excess beyond, strict
            send_plane(10'h155, 10'h2AA, 700, 700 * 256, 131071, 1);  // largest value
            send_plane(5, 6, 7, 7 * 256, 0, 1);                       // zero sum, no result
            send_plane(0, 0, 0, -262144, 131071, 1);                  // most negative centre
            send_plane(1023, 0, 1023, 262143, 131071, 1);             // top centre, sliver overlap
            send_plane(9, 9, 5, 5 * 256 - 128, 40000, 0);             // slab straddles low edge
            send_plane(9, 9, 5, 5 * 256 + 128, 40000, 1);             // slab straddles high edge
            send_plane(4, 4, 12, 12 * 256 + 256, 50000, 0);           // touches high edge only
            send_plane(4, 4, 12, 12 * 256 - 256, 50000, 0);           // touches low edge only
            send_plane(4, 4, 12, 12 * 256 - 100, 30000, 1);
            send_plane(0, 1023, 0, 100, 65536, 0);                    // two planes push past one
            send_plane(0, 1023, 0, -100, 65536, 1);
         end

         quota = items_sent + ((k == 3) ? 30 : 150);
         while (items_sent < quota)
            send_voxel_run();
      end

      settle(20);
      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: slab_weighted_plane_accumulator_unit.f
rtl/swpa_pkg.sv
rtl/swpa_csr.sv
rtl/swpa_front.sv
rtl/swpa_queue.sv
rtl/swpa_back.sv
rtl/slab_weighted_plane_accumulator_unit.sv
rtl/swpa_checker.sv
dv/slab_weighted_plane_accumulator_unit_tb.sv
